[hdl/dmtc_pkg.sv]
// shared types and constants for the dhcp message-type counter
`timescale 1ns / 1ps

package dmtc_pkg;

  // counter width default and widest supported counter
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int MAX_COUNT_W     = 64;
  localparam int OUT_COUNT_W     = 32;

  // configuration register indexes
  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_SERVER_PORT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIENT_PORT = 8'd1;

  localparam logic [15:0] SERVER_PORT_RST = 16'd67;
  localparam logic [15:0] CLIENT_PORT_RST = 16'd68;

  // frame layout
  localparam logic [7:0]  ETH_TYPE_HI  = 8'h08;
  localparam logic [7:0]  ETH_TYPE_LO  = 8'h00;
  localparam logic [15:0] POS_ETH_HI   = 16'd12;
  localparam logic [15:0] POS_ETH_LO   = 16'd13;
  localparam logic [15:0] POS_IP_VIHL  = 16'd14;
  localparam logic [15:0] POS_IP_PROTO = 16'd23;
  localparam logic [15:0] POS_MAX      = 16'hFFFF;
  localparam logic [6:0]  ETH_HDR      = 7'd14;
  localparam logic [5:0]  IP_HDR_MIN   = 6'd20;
  localparam logic [7:0]  UDP_PROTO    = 8'd17;
  localparam logic [15:0] UDP_PORTS_END = 16'd4;
  localparam logic [15:0] UDP_HDR_END  = 16'd6;
  localparam logic [15:0] OPT_START    = 16'd248;

  // dhcp option codes
  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_END      = 8'd255;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;

  // message type values
  localparam logic [7:0] MSG_DISCOVER = 8'd1;
  localparam logic [7:0] MSG_OFFER    = 8'd2;
  localparam logic [7:0] MSG_REQUEST  = 8'd3;
  localparam logic [7:0] MSG_ACK      = 8'd5;

  // counter selects
  localparam logic [1:0] CNT_DISCOVER = 2'd0;
  localparam logic [1:0] CNT_OFFER    = 2'd1;
  localparam logic [1:0] CNT_REQUEST  = 2'd2;
  localparam logic [1:0] CNT_ACK      = 2'd3;

  // event queue between parser and counters
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic       bump;    // bump the selected counter
    logic [1:0] sel;     // which counter
    logic       last;    // end of frame, emit a result
    logic       seen;    // frame held a message-type option
    logic [7:0] mtype;   // last message type, zero if none
  } dmtc_event_t;

endpackage

[hdl/dmtc_front.sv]
// byte parser: qualifies frames, walks dhcp options, issues counter events
`timescale 1ns / 1ps

module dmtc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            byte_valid,
  input  logic [7:0]                      frame_byte,
  input  logic                            frame_last,
  input  logic                            cfg_we,
  input  logic [dmtc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data,
  output logic                            ev_push,
  output dmtc_pkg::dmtc_event_t           ev
);
  import dmtc_pkg::*;

  typedef enum logic [3:0] {
    PH_TYPE = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_DATA = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  logic [15:0] server_port, client_port;
  logic [15:0] pos, pos_next;
  logic [5:0]  ihb, ihb_next;
  logic [6:0]  shift, shift_next;
  logic [15:0] udp_len, udp_len_next;
  logic        qual, qual_next;
  phase_t      phase, phase_next;
  logic [7:0]  code, code_next;
  logic [7:0]  remain, remain_next;
  logic        found, found_next;
  logic [7:0]  ftype, ftype_next;
  logic [15:0] rel;
  logic        bump;
  logic [1:0]  sel;

  always_comb begin
    pos_next    = pos;
    ihb_next    = ihb;
    shift_next  = shift;
    udp_len_next = udp_len;
    qual_next   = qual;
    phase_next  = phase;
    code_next   = code;
    remain_next = remain;
    found_next  = found;
    ftype_next  = ftype;
    bump        = 1'b0;
    sel         = CNT_DISCOVER;
    rel         = pos - {9'd0, shift};
    if (pos != POS_MAX) begin
      if (pos == 16'd0) qual_next = 1'b1;
      if (pos == POS_ETH_HI && frame_byte != ETH_TYPE_HI) qual_next = 1'b0;
      if (pos == POS_ETH_LO && frame_byte != ETH_TYPE_LO) qual_next = 1'b0;
      if (pos == POS_IP_VIHL) begin
        ihb_next   = {frame_byte[3:0], 2'b00};
        shift_next = ETH_HDR + {1'b0, ihb_next};
        if (ihb_next < IP_HDR_MIN) qual_next = 1'b0;
      end
      if (pos == POS_IP_PROTO && frame_byte != UDP_PROTO) qual_next = 1'b0;
      if (qual && pos > POS_IP_PROTO && pos >= {9'd0, shift}) begin
        if (rel < UDP_HDR_END) begin
          if (!rel[0]) begin
            udp_len_next = {frame_byte, 8'h00};
          end else begin
            udp_len_next = {udp_len[15:8], frame_byte};
            if (rel < UDP_PORTS_END && udp_len_next != server_port &&
                udp_len_next != client_port) qual_next = 1'b0;
          end
        end else if (rel >= OPT_START && rel < udp_len) begin
          unique case (phase)
            PH_TYPE: begin
              if (frame_byte == OPT_END) begin
                phase_next = PH_DONE;
              end else if (frame_byte != OPT_PAD) begin
                code_next  = frame_byte;
                phase_next = PH_LEN;
              end
            end
            PH_LEN: begin
              remain_next = frame_byte;
              if (code != OPT_MSG_TYPE || frame_byte != 8'd1) code_next = 8'd0;
              phase_next = (frame_byte == 8'd0) ? PH_TYPE : PH_DATA;
            end
            PH_DATA: begin
              if (code == OPT_MSG_TYPE) begin
                found_next = 1'b1;
                ftype_next = frame_byte;
                unique case (frame_byte)
                  MSG_DISCOVER: begin bump = 1'b1; sel = CNT_DISCOVER; end
                  MSG_OFFER:    begin bump = 1'b1; sel = CNT_OFFER;    end
                  MSG_REQUEST:  begin bump = 1'b1; sel = CNT_REQUEST;  end
                  MSG_ACK:      begin bump = 1'b1; sel = CNT_ACK;      end
                  default:      bump = 1'b0;
                endcase
              end
              remain_next = remain - 8'd1;
              if (remain_next == 8'd0) begin
                phase_next = PH_TYPE;
                code_next  = 8'd0;
              end
            end
            PH_DONE: phase_next = PH_DONE;
            default: phase_next = PH_TYPE;
          endcase
        end
      end
      pos_next = pos + 16'd1;
    end
  end

  assign ev_push  = byte_valid && (bump || frame_last);
  assign ev.bump  = bump;
  assign ev.sel   = sel;
  assign ev.last  = frame_last;
  assign ev.seen  = found_next;
  assign ev.mtype = found_next ? ftype_next : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      server_port <= SERVER_PORT_RST;
      client_port <= CLIENT_PORT_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_SERVER_PORT) server_port <= cfg_data;
      if (cfg_index == REG_CLIENT_PORT) client_port <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (byte_valid && frame_last)) begin
      pos     <= 16'd0;
      ihb     <= 6'd0;
      shift   <= 7'd0;
      udp_len <= 16'd0;
      qual    <= 1'b0;
      phase   <= PH_TYPE;
      code    <= 8'd0;
      remain  <= 8'd0;
      found   <= 1'b0;
      ftype   <= 8'd0;
    end else if (byte_valid) begin
      pos     <= pos_next;
      ihb     <= ihb_next;
      shift   <= shift_next;
      udp_len <= udp_len_next;
      qual    <= qual_next;
      phase   <= phase_next;
      code    <= code_next;
      remain  <= remain_next;
      found   <= found_next;
      ftype   <= ftype_next;
    end
  end

endmodule

[hdl/dmtc_queue.sv]
// short event fifo between parser and counter stage
`timescale 1ns / 1ps

module dmtc_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  dmtc_pkg::dmtc_event_t push_ev,
  output logic                  full,
  output logic                  not_empty,
  input  logic                  pop,
  output dmtc_pkg::dmtc_event_t head
);
  import dmtc_pkg::*;

  dmtc_event_t             slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]       count;

  assign full      = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (QUEUE_AW + 1)'(push) - (QUEUE_AW + 1)'(pop);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("event pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !not_empty |-> !pop)
    else $error("event popped from empty queue");

endmodule

[hdl/dmtc_back.sv]
// counter stage: saturating type counters and registered result word
`timescale 1ns / 1ps

module dmtc_back #(
  parameter int COUNT_WIDTH = dmtc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  dmtc_pkg::dmtc_event_t q_head,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic                  out_seen,
  output logic [7:0]            out_type,
  output logic [3:0][dmtc_pkg::OUT_COUNT_W-1:0] out_cnt
);
  import dmtc_pkg::*;

  logic [3:0][COUNT_WIDTH-1:0] cnt, cnt_next;
  logic [MAX_COUNT_W-1:0]      wide [4];

  assign q_pop = q_valid && (!q_head.last || !m_tvalid || m_tready);

  always_comb begin
    cnt_next = cnt;
    if (q_pop && q_head.bump && cnt[q_head.sel] != {COUNT_WIDTH{1'b1}})
      cnt_next[q_head.sel] = cnt[q_head.sel] + 1'b1;
    for (int k = 0; k < 4; k++) wide[k] = MAX_COUNT_W'(cnt_next[k]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (q_pop && q_head.last) m_tvalid <= 1'b1;
      else if (m_tready)        m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.last) begin
      out_seen <= q_head.seen;
      out_type <= q_head.mtype;
      for (int k = 0; k < 4; k++) out_cnt[k] <= wide[k][OUT_COUNT_W-1:0];
    end
  end

  a_stall_no_end: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tready) |-> !(q_pop && q_head.last))
    else $error("result overwritten while stalled");
  a_end_shows: assert property (@(posedge clk) disable iff (rst)
      (q_pop && q_head.last) |=> m_tvalid)
    else $error("frame end popped without a result");
  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
      !(q_pop && q_head.bump) |=> $stable(cnt))
    else $error("counter changed without a bump event");

endmodule

[hdl/dhcp_message_type_counter.sv]
// top level of the dhcp message-type counter
`timescale 1ns / 1ps
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+------------------------------------------
//  s_axis   | in  | s_tvalid / s_tready | s_tdata frame_byte, s_tlast frame_last
//  m_axis   | out | m_tvalid / m_tready | m_tuser dhcp_seen, m_tdata type + counts
//  cfg      | in  | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
//  one word per cycle on the input; the parser keeps state for the frame in progress
//  and forwards only counter bumps and frame ends into a four-entry event queue
//  the counter stage drains one event per cycle, so the input stalls only when the
//  result register is held by m_tready low long enough to fill the queue
//  m_tvalid rises once the frame-end event has passed the event queue into the result
//  register, later only while an earlier result is still held by m_tready low
//  rst is synchronous: counters clear, ports return to 67 (server) and 68 (client)

module dhcp_message_type_counter #(
  parameter int COUNT_WIDTH = dmtc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input words
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] frame_byte
  input  logic                             s_tlast,   // frame_last
  // results, one per frame
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [135:0]                     m_tdata,   // [7:0] message_type,
                                                      // [39:8] discover_count,
                                                      // [71:40] offer_count,
                                                      // [103:72] request_count,
                                                      // [135:104] ack_count
  output logic                             m_tuser,   // dhcp_seen
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dmtc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                      cfg_data
);
  import dmtc_pkg::*;

  logic        q_full, q_not_empty, q_pop, ev_push, in_acc;
  dmtc_event_t ev, q_head;
  logic [7:0]  out_type;
  logic [3:0][OUT_COUNT_W-1:0] out_cnt;

  // input is held only by a full event queue
  assign s_tready  = !q_full;
  assign in_acc    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // parser and port registers
  dmtc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (in_acc),
    .frame_byte (s_tdata),
    .frame_last (s_tlast),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ev_push    (ev_push),
    .ev         (ev)
  );

  // decoupling queue
  dmtc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (ev_push),
    .push_ev   (ev),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .head      (q_head)
  );

  // counters and result register
  dmtc_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_not_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .out_seen (m_tuser),
    .out_type (out_type),
    .out_cnt  (out_cnt)
  );

  // pack result word, type in the low byte then counters in select order
  assign m_tdata = {out_cnt[CNT_ACK], out_cnt[CNT_REQUEST], out_cnt[CNT_OFFER],
                    out_cnt[CNT_DISCOVER], out_type};

endmodule

[sim/tb_dhcp_message_type_counter.sv]
// testbench for the dhcp message-type counter: directed frames, then random traffic
`timescale 1ns / 1ps

module tb_dhcp_message_type_counter;
  import dmtc_pkg::*;

  localparam int RESET_CYCLES     = 8;
  localparam int IDLE_PCT         = 18;
  localparam int HOLD_CYCLES      = 300;
  localparam int SETTLE_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int FRAMES_PER_PHASE = 2;
  localparam int SQUEEZE_FRAMES   = 16;
  localparam int RAW_MAX_LEN      = 6;
  localparam int NUM_PHASES       = 5;
  localparam int NO_VAL           = -1;
  localparam int MAX_REPORTS      = 10;
  // index that maps to no register, a write to it must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = '1;

  // one result word, fields in the order they sit on the bus
  typedef struct packed {
    logic        seen;
    logic [7:0]  mtype;
    logic [31:0] discover;
    logic [31:0] offer;
    logic [31:0] request;
    logic [31:0] ack;
  } tally_t;

  typedef enum logic [1:0] {
    OPT_WANT_CODE, OPT_WANT_LEN, OPT_IN_DATA, OPT_STOPPED
  } opt_state_e;

  typedef enum int { SH_RAW, SH_DHCP } shape_e;

  // ways to spoil an otherwise valid dhcp frame
  typedef enum int {
    FL_NONE, FL_ETH_HI, FL_ETH_LO, FL_PROTO, FL_SHORT_IHL, FL_SRC_PORT,
    FL_DST_PORT, FL_SHORT_UDP, FL_TRUNC, FL_OVERLONG
  } flaw_e;

  // raw frames: val is the fill byte, count the length
  // dhcp frames: val is the leading message type, count the number of extra options
  typedef struct {
    shape_e shape;
    flaw_e  flaw;
    int     ihl;
    int     val;
    int     count;
    bit     typed;
    tally_t want;
  } plan_t;

  logic         clk;
  logic         rst       = 1'b1;
  logic         s_tvalid  = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata   = '0;   // [7:0] frame_byte
  logic         s_tlast   = 1'b0; // frame_last
  logic         m_tvalid;
  logic         m_tready  = 1'b1;
  logic [135:0] m_tdata;          // [7:0] message_type, [39:8] discover_count,
                                  // [71:40] offer_count, [103:72] request_count,
                                  // [135:104] ack_count
  logic         m_tuser;          // dhcp_seen
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]  cfg_data  = '0;

  dhcp_message_type_counter dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // classifier state, mirrors the block from reset on
  // ---------------------------------------------------------------------------
  logic [15:0] port_server = SERVER_PORT_RST;
  logic [15:0] port_client = CLIENT_PORT_RST;
  logic [15:0] frame_pos   = '0;
  logic [5:0]  ihl_bytes   = '0;
  logic [15:0] udp_word    = '0;
  logic [15:0] udp_base    = '0;
  bit          frame_good  = 1'b0;
  opt_state_e  opt_state   = OPT_WANT_CODE;
  logic [7:0]  opt_code    = '0;
  logic [7:0]  opt_left    = '0;
  bit          type_seen   = 1'b0;
  logic [7:0]  type_value  = '0;
  logic [31:0] tally_cnt [4] = '{default: '0};

  tally_t      pending_tallies [$];
  logic [7:0]  wire_bytes [$];
  int          miss_count   = 0;
  int          quiet_cycles = 0;
  bit          calm     = 1'b0;  // no idling on either side while set
  bit          squeeze  = 1'b0;  // asks the receiver for its long hold-off
  bit          squeezed = 1'b0;

  function automatic void bump_count(input logic [1:0] k);
    if (tally_cnt[k] != '1) tally_cnt[k]++;
  endfunction

  // advances the classifier by one byte, returns 1 with the result on a frame end
  function automatic bit classify_byte(input logic [7:0] b, input logic last,
                                       output tally_t res);
    logic [15:0] rel;
    if (frame_pos < POS_MAX) begin
      if (frame_pos == 16'd0) frame_good = 1'b1;
      if (frame_pos == POS_ETH_HI && b != ETH_TYPE_HI) frame_good = 1'b0;
      if (frame_pos == POS_ETH_LO && b != ETH_TYPE_LO) frame_good = 1'b0;
      if (frame_pos == POS_IP_VIHL) begin
        ihl_bytes = {b[3:0], 2'b00};
        udp_base  = 16'(ETH_HDR) + 16'(ihl_bytes);
        if (ihl_bytes < IP_HDR_MIN) frame_good = 1'b0;
      end
      if (frame_pos == POS_IP_PROTO && b != UDP_PROTO) frame_good = 1'b0;
      if (frame_good && frame_pos > POS_IP_PROTO && frame_pos >= udp_base) begin
        rel = frame_pos - udp_base;
        if (rel < UDP_HDR_END) begin
          // ports then length, big endian pairs
          if (!rel[0]) begin
            udp_word = {b, 8'h00};
          end else begin
            udp_word = udp_word | {8'h00, b};
            if (rel < UDP_PORTS_END && udp_word != port_server && udp_word != port_client)
              frame_good = 1'b0;
          end
        end else if (rel >= OPT_START && rel < udp_word) begin
          case (opt_state)
            OPT_WANT_CODE: begin
              if (b == OPT_END) begin
                opt_state = OPT_STOPPED;
              end else if (b != OPT_PAD) begin
                opt_code  = b;
                opt_state = OPT_WANT_LEN;
              end
            end
            OPT_WANT_LEN: begin
              opt_left = b;
              if (opt_code != OPT_MSG_TYPE || b != 8'd1) opt_code = '0;
              opt_state = (b == 8'd0) ? OPT_WANT_CODE : OPT_IN_DATA;
            end
            OPT_IN_DATA: begin
              if (opt_code == OPT_MSG_TYPE) begin
                type_seen  = 1'b1;
                type_value = b;
                case (b)
                  MSG_DISCOVER: bump_count(CNT_DISCOVER);
                  MSG_OFFER:    bump_count(CNT_OFFER);
                  MSG_REQUEST:  bump_count(CNT_REQUEST);
                  MSG_ACK:      bump_count(CNT_ACK);
                  default: ;
                endcase
              end
              opt_left--;
              if (opt_left == 8'd0) begin
                opt_state = OPT_WANT_CODE;
                opt_code  = '0;
              end
            end
            default: ;
          endcase
        end
      end
      frame_pos++;
    end
    if (!last) return 1'b0;
    res = '{type_seen, type_seen ? type_value : 8'd0, tally_cnt[CNT_DISCOVER],
            tally_cnt[CNT_OFFER], tally_cnt[CNT_REQUEST], tally_cnt[CNT_ACK]};
    frame_pos  = '0;
    ihl_bytes  = '0;
    udp_word   = '0;
    udp_base   = '0;
    frame_good = 1'b0;
    opt_state  = OPT_WANT_CODE;
    opt_code   = '0;
    opt_left   = '0;
    type_seen  = 1'b0;
    type_value = '0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // frame builders
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] one_bit();
    return 8'd1 << $urandom_range(7);
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(4))
      0:       return MSG_DISCOVER;
      1:       return MSG_OFFER;
      2:       return MSG_REQUEST;
      3:       return MSG_ACK;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] stray_port();
    logic [15:0] p;
    do p = 16'($urandom); while (p == port_server || p == port_client);
    return p;
  endfunction

  task automatic build_raw(input int len, input int fill);
    wire_bytes = {};
    repeat (len) wire_bytes.push_back(fill == NO_VAL ? 8'($urandom) : 8'(fill));
  endtask

  task automatic build_dhcp(input flaw_e flaw, input int ihl, input int lead,
                            input int n_opts);
    logic [7:0]  opts [$];
    logic [15:0] sport, dport, ulen;
    int          words, len, code;
    wire_bytes = {};
    opts = {};
    if (flaw == FL_SHORT_IHL && ihl >= 5) ihl = $urandom_range(4);
    words = (ihl < 5) ? 5 : ihl;
    // ethernet header
    repeat (12) wire_bytes.push_back(8'($urandom));
    wire_bytes.push_back(flaw == FL_ETH_HI ? ETH_TYPE_HI ^ one_bit() : ETH_TYPE_HI);
    wire_bytes.push_back(flaw == FL_ETH_LO ? ETH_TYPE_LO ^ one_bit() : ETH_TYPE_LO);
    // ipv4 header, version nibble is don't-care
    wire_bytes.push_back({4'($urandom), 4'(ihl)});
    repeat (8) wire_bytes.push_back(8'($urandom));
    wire_bytes.push_back(flaw == FL_PROTO ? UDP_PROTO ^ one_bit() : UDP_PROTO);
    repeat (words * 4 - 10) wire_bytes.push_back(8'($urandom));
    // udp ports
    sport = $urandom_range(1) ? port_server : port_client;
    dport = $urandom_range(1) ? port_server : port_client;
    if (flaw == FL_SRC_PORT) sport = stray_port();
    if (flaw == FL_DST_PORT) dport = stray_port();
    // options
    if (lead != NO_VAL) begin
      opts.push_back(OPT_MSG_TYPE);
      opts.push_back(8'd1);
      opts.push_back(8'(lead));
    end
    repeat (n_opts) begin
      case ($urandom_range(9))
        0, 1: opts.push_back(OPT_PAD);
        2, 3, 4: begin
          opts.push_back(OPT_MSG_TYPE);
          opts.push_back(8'd1);
          opts.push_back(pick_type());
        end
        5: begin
          // message type with a length other than one is not counted
          len = $urandom_range(2);
          if (len == 1) len = 3;
          opts.push_back(OPT_MSG_TYPE);
          opts.push_back(8'(len));
          repeat (len) opts.push_back(8'($urandom));
        end
        9: opts.push_back($urandom_range(3) == 0 ? OPT_END : OPT_PAD);
        default: begin
          code = $urandom_range(254, 1);
          if (code == OPT_MSG_TYPE) code++;
          len = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(6);
          opts.push_back(8'(code));
          opts.push_back(8'(len));
          repeat (len) opts.push_back(8'($urandom));
        end
      endcase
    end
    ulen = 16'(OPT_START + opts.size());
    if (flaw == FL_SHORT_UDP) ulen = 16'($urandom_range(OPT_START));
    else if (flaw == FL_OVERLONG) ulen = POS_MAX;
    else if (n_opts > 0 && $urandom_range(9) == 0)
      ulen = 16'(OPT_START + $urandom_range(opts.size()));
    wire_bytes.push_back(sport[15:8]);
    wire_bytes.push_back(sport[7:0]);
    wire_bytes.push_back(dport[15:8]);
    wire_bytes.push_back(dport[7:0]);
    wire_bytes.push_back(ulen[15:8]);
    wire_bytes.push_back(ulen[7:0]);
    repeat (2) wire_bytes.push_back(8'($urandom));
    // fixed dhcp header and cookie, neither is looked at
    repeat (240) wire_bytes.push_back(8'($urandom));
    foreach (opts[i]) wire_bytes.push_back(opts[i]);
    if (flaw == FL_OVERLONG) begin
      // pads up to the saturation point, then a message type that must be ignored
      while (wire_bytes.size() < POS_MAX) wire_bytes.push_back(OPT_PAD);
      wire_bytes.push_back(OPT_MSG_TYPE);
      wire_bytes.push_back(8'd1);
      wire_bytes.push_back(MSG_OFFER);
    end else begin
      repeat ($urandom_range(6)) wire_bytes.push_back(8'($urandom));
    end
    if (flaw == FL_TRUNC) begin
      len = $urandom_range(wire_bytes.size() - 1, 1);
      while (wire_bytes.size() > len) void'(wire_bytes.pop_back());
    end
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [7:0] b, input logic last, input bit typed,
                           input tally_t want);
    tally_t got;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    if (classify_byte(b, last, got)) pending_tallies.push_back(typed ? want : got);
  endtask

  task automatic send_frame(input bit typed, input tally_t want);
    foreach (wire_bytes[i])
      send_word(wire_bytes[i], i == wire_bytes.size() - 1, typed, want);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SERVER_PORT: port_server = val;
      REG_CLIENT_PORT: port_client = val;
      default: ;
    endcase
  endtask

  task automatic set_ports(input logic [15:0] server, input logic [15:0] client);
    put_reg(REG_SERVER_PORT, server);
    put_reg(REG_CLIENT_PORT, client);
    put_reg(REG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // directed frames; counts typed in are cumulative from reset
  // ---------------------------------------------------------------------------
  plan_t plans [4] = '{
    // one-word frames after reset
    '{SH_RAW,  FL_NONE,      5, 8'h00,        1, 1'b1, '{1'b0, 8'd0,   0, 0, 0, 0}},
    '{SH_RAW,  FL_NONE,      5, 8'hFF,        1, 1'b1, '{1'b0, 8'd0,   0, 0, 0, 0}},
    // counted type on the default ports
    '{SH_DHCP, FL_NONE,      5, MSG_DISCOVER, 0, 1'b1, '{1'b1, 8'd1,   1, 0, 0, 0}},
    // stray source port, the ack must not be counted
    '{SH_DHCP, FL_SRC_PORT,  6, MSG_ACK,      0, 1'b1, '{1'b0, 8'd0,   1, 0, 0, 0}}
  };

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] port;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plans[i]) begin
      if (plans[i].shape == SH_RAW) build_raw(plans[i].count, plans[i].val);
      else build_dhcp(plans[i].flaw, plans[i].ihl, plans[i].val, plans[i].count);
      send_frame(plans[i].typed, plans[i].want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // ports change only with nothing in flight
      s_tvalid <= 1'b0;
      drain();
      case (ph)
        0: set_ports(16'h0000, 16'hFFFF);
        1: set_ports(16'hFFFF, 16'h0000);
        2: set_ports(16'($urandom), 16'($urandom));
        3: begin
          port = 16'($urandom);
          set_ports(port, port);
        end
        default: set_ports(SERVER_PORT_RST, CLIENT_PORT_RST);
      endcase
      calm = (ph == 2);
      if (ph == 0) begin
        // back-to-back tiny frames against a stalled receiver fill the event queue
        squeeze = 1'b1;
        repeat (SQUEEZE_FRAMES) begin
          build_raw($urandom_range(3, 1), NO_VAL);
          send_frame(1'b0, '0);
        end
      end
      if (calm) begin
        // one full dhcp frame on the new ports with no idling on either side
        build_dhcp(FL_NONE, $urandom_range(15, 5), int'(pick_type()), $urandom_range(6));
        send_frame(1'b0, '0);
      end
      repeat (FRAMES_PER_PHASE) begin
        build_raw($urandom_range(RAW_MAX_LEN, 1), NO_VAL);
        send_frame(1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    drain();
    miss_count += pending_tallies.size();
    if (miss_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // result checker
  always @(posedge clk) begin
    tally_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tuser, m_tdata[7:0], m_tdata[39:8], m_tdata[71:40],
              m_tdata[103:72], m_tdata[135:104]};
      if (pending_tallies.size() == 0) begin
        if (miss_count < MAX_REPORTS)
          $display("unexpected result word: seen %0d type %0d", got.seen, got.mtype);
        miss_count++;
      end else begin
        want = pending_tallies.pop_front();
        if (got.seen != want.seen || got.mtype != want.mtype ||
            got.discover != want.discover || got.offer != want.offer ||
            got.request != want.request || got.ack != want.ack) begin
          if (miss_count < MAX_REPORTS) begin
            $display("result mismatch (expected/actual): seen %0d/%0d type %0d/%0d",
                     want.seen, got.seen, want.mtype, got.mtype);
            $display("  discover %0d/%0d offer %0d/%0d request %0d/%0d ack %0d/%0d",
                     want.discover, got.discover, want.offer, got.offer,
                     want.request, got.request, want.ack, got.ack);
          end
          miss_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[sim.f]
hdl/dmtc_pkg.sv
hdl/dmtc_front.sv
hdl/dmtc_queue.sv
hdl/dmtc_back.sv
hdl/dhcp_message_type_counter.sv
sim/tb_dhcp_message_type_counter.sv
